FILE: hw/rtl/jrr_pkg.sv
// Shared types and constants for the journal record replay block.
// No dependencies; every file of the block but jrr_if imports this package.
`default_nettype none

package jrr_pkg;

  // Journal header length and record type words
  localparam logic [16:0] HDR_BYTES   = 17'd8;
  localparam logic [31:0] TYPE_DATA   = 32'd1;
  localparam logic [31:0] TYPE_COMMIT = 32'd2;
  localparam logic [12:0] COUNT_MAX   = 13'h1FFF;

  // Width of the slot field in a command; covers the largest queue depth
  localparam int unsigned SLOT_W = 7;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_RESTART = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_WRITE   = 3'd2,
    KIND_EMPTY   = 3'd3,
    KIND_STOP    = 3'd4
  } kind_e;

  // Command from the classifier to the executor.
  // For a data record, slot is the queue entry to fill; for a commit with
  // queued writes, slot is the index of the last entry to drain.
  typedef struct packed {
    kind_e              kind;
    logic [31:0]        block;
    logic [15:0]        offset;
    logic [12:0]        count;
    logic [SLOT_W-1:0]  slot;
  } jrr_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/jrr_if.sv
// Valid/ready channel interfaces for record headers in and replay results out.
// Depends on nothing.
`default_nettype none

interface jrr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] record_type;
  logic [31:0] record_size;
  logic [31:0] target_block;

  modport source (output valid, action, record_type, record_size, target_block,
                  input ready);
  modport sink   (input valid, action, record_type, record_size, target_block,
                  output ready);
endinterface

interface jrr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] dest_block;
  logic [15:0] image_offset;
  logic [12:0] commits_applied;
  logic        last;

  modport source (output valid, kind, dest_block, image_offset, commits_applied, last,
                  input ready);
  modport sink   (input valid, kind, dest_block, image_offset, commits_applied, last,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/jrr_cmdq.sv
// Two-entry command queue between the classifier and the executor.
// Depends on jrr_pkg for the command type.
`default_nettype none

module jrr_cmdq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire jrr_pkg::jrr_cmd_t push_cmd_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output jrr_pkg::jrr_cmd_t      pop_cmd_o
);
  import jrr_pkg::*;

  jrr_cmd_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o    = cnt_q[1];
  assign empty_o   = (cnt_q == 2'd0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/jrr_front.sv
// Record classifier: holds the journal length register and the replay
// position, checks each header and issues one command per item. Uses jrr_pkg.
`default_nettype none

module jrr_front #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned BLOCK_BYTES = 4096,
  parameter int unsigned LOG_BLOCKS  = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [16:0]  cfg_wdata_i,
  jrr_in_if.sink            rec_i,
  output logic              push_o,
  output jrr_pkg::jrr_cmd_t cmd_o,
  input  wire logic         full_i
);
  import jrr_pkg::*;

  localparam int unsigned QCW        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QIW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LOG_BYTES  = LOG_BLOCKS * BLOCK_BYTES;
  localparam logic [31:0] DATA_BYTES = 32'(12 + BLOCK_BYTES);

  logic [16:0]    used_q;
  logic [16:0]    pos_q, pos_d;
  logic [QCW-1:0] qcnt_q, qcnt_d;
  logic           halted_q, halted_d;
  logic [12:0]    ccnt_q, ccnt_d;

  logic           accept;
  logic [16:0]    log_end;
  logic           bad_hdr;
  logic [16:0]    img_pos;
  logic [QCW-1:0] qcnt_dec;
  logic [12:0]    ccnt_inc;

  assign rec_i.ready = !full_i;
  assign accept      = rec_i.valid && !full_i;
  assign push_o      = accept;

  // Effective end of the log; an out-of-range length means an empty log
  assign log_end = ((used_q < HDR_BYTES) || (used_q > 17'(LOG_BYTES))) ? HDR_BYTES : used_q;

  // Header fits, size sane, record stays inside the log
  assign bad_hdr = ({1'b0, pos_q} + {1'b0, HDR_BYTES} > {1'b0, log_end})
                || (rec_i.record_size < 32'(HDR_BYTES))
                || ({16'd0, pos_q} + {1'b0, rec_i.record_size} > {16'd0, log_end});

  assign img_pos  = pos_q + 17'd12;
  assign qcnt_dec = qcnt_q - QCW'(1);
  assign ccnt_inc = (ccnt_q < COUNT_MAX) ? ccnt_q + 13'd1 : ccnt_q;

  // Classify the presented item
  always_comb begin
    cmd_o.kind   = KIND_STOP;
    cmd_o.block  = 32'd0;
    cmd_o.offset = 16'd0;
    cmd_o.count  = ccnt_q;
    cmd_o.slot   = '0;
    pos_d        = pos_q;
    qcnt_d       = qcnt_q;
    halted_d     = halted_q;
    ccnt_d       = ccnt_q;
    if (!rec_i.action) begin
      cmd_o.kind  = KIND_RESTART;
      cmd_o.count = 13'd0;
      pos_d       = HDR_BYTES;
      qcnt_d      = '0;
      halted_d    = 1'b0;
      ccnt_d      = 13'd0;
    end else if (halted_q || bad_hdr) begin
      halted_d = 1'b1;
    end else if (rec_i.record_type == TYPE_DATA) begin
      if ((rec_i.record_size == DATA_BYTES) && (qcnt_q < QCW'(QUEUE_DEPTH))) begin
        cmd_o.kind   = KIND_DATA;
        cmd_o.block  = rec_i.target_block;
        cmd_o.offset = img_pos[15:0];
        cmd_o.slot   = SLOT_W'(qcnt_q[QIW-1:0]);
        qcnt_d       = qcnt_q + QCW'(1);
        pos_d        = pos_q + DATA_BYTES[16:0];
      end else begin
        halted_d = 1'b1;
      end
    end else if (rec_i.record_type == TYPE_COMMIT) begin
      if (rec_i.record_size == 32'(HDR_BYTES)) begin
        cmd_o.kind  = (qcnt_q == '0) ? KIND_EMPTY : KIND_WRITE;
        cmd_o.count = ccnt_inc;
        cmd_o.slot  = SLOT_W'(qcnt_dec[QIW-1:0]);
        ccnt_d      = ccnt_inc;
        qcnt_d      = '0;
        pos_d       = pos_q + HDR_BYTES;
      end else begin
        halted_d = 1'b1;
      end
    end else begin
      halted_d = 1'b1;
    end
  end

  // Hold the length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= HDR_BYTES;
    end else if (cfg_we_i) begin
      used_q <= cfg_wdata_i;
    end
  end

  // Update replay state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= HDR_BYTES;
      qcnt_q   <= '0;
      halted_q <= 1'b0;
      ccnt_q   <= 13'd0;
    end else if (accept) begin
      pos_q    <= pos_d;
      qcnt_q   <= qcnt_d;
      halted_q <= halted_d;
      ccnt_q   <= ccnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/jrr_back.sv
// Command executor: owns the queued-write memory, drains it on a commit one entry per
// cycle while the output is free and drives the result output register. Uses jrr_pkg.
`default_nettype none

module jrr_back #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              empty_i,
  input  wire jrr_pkg::jrr_cmd_t cmd_i,
  output logic                   pop_o,
  jrr_out_if.source              res_o
);
  import jrr_pkg::*;

  localparam int unsigned QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e         state_q, state_d;
  logic [QIW-1:0] idx_q, idx_d;
  logic [QIW-1:0] last_q, last_d;
  logic [12:0]    cnt_q, cnt_d;

  logic [31:0]    blk_mem [QUEUE_DEPTH];
  logic [15:0]    ofs_mem [QUEUE_DEPTH];
  logic [31:0]    rd_blk_q;
  logic [15:0]    rd_ofs_q;
  logic           mem_we;

  logic           out_valid_q, out_valid_d;
  kind_e          out_kind_q, out_kind_d;
  logic [31:0]    out_blk_q, out_blk_d;
  logic [15:0]    out_ofs_q, out_ofs_d;
  logic [12:0]    out_cnt_q, out_cnt_d;
  logic           out_last_q, out_last_d;
  logic           out_free;

  assign out_free = !out_valid_q || res_o.ready;

  // Sequence commands and fill the output register
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q && !res_o.ready;
    out_kind_d  = out_kind_q;
    out_blk_d   = out_blk_q;
    out_ofs_d   = out_ofs_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          if (cmd_i.kind == KIND_WRITE) begin
            state_d = ST_DRAIN;
            idx_d   = '0;
            last_d  = cmd_i.slot[QIW-1:0];
            cnt_d   = cmd_i.count;
          end else begin
            mem_we      = (cmd_i.kind == KIND_DATA);
            out_valid_d = 1'b1;
            out_kind_d  = cmd_i.kind;
            out_blk_d   = 32'd0;
            out_ofs_d   = 16'd0;
            out_cnt_d   = cmd_i.count;
            out_last_d  = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_WRITE;
          out_blk_d   = rd_blk_q;
          out_ofs_d   = rd_ofs_q;
          out_cnt_d   = cnt_q;
          out_last_d  = (idx_q == last_q);
          if (idx_q == last_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + QIW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Queued-write memory; read data follows the next drain index
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      blk_mem[cmd_i.slot[QIW-1:0]] <= cmd_i.block;
      ofs_mem[cmd_i.slot[QIW-1:0]] <= cmd_i.offset;
    end
    rd_blk_q <= blk_mem[idx_d];
    rd_ofs_q <= ofs_mem[idx_d];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Drain bounds and result payload
  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    cnt_q      <= cnt_d;
    out_kind_q <= out_kind_d;
    out_blk_q  <= out_blk_d;
    out_ofs_q  <= out_ofs_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.kind            = out_kind_q;
  assign res_o.dest_block      = out_blk_q;
  assign res_o.image_offset    = out_ofs_q;
  assign res_o.commits_applied = out_cnt_q;
  assign res_o.last            = out_last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/journal_record_replay.sv
// Journal record replay: walks a write-ahead log one record header at a time.
//
// Channels: rec_i takes record headers (action, record_type, record_size,
// target_block); res_o gives result items (kind, dest_block, image_offset,
// commits_applied, last). Both transfer when valid and ready are high at a
// clock edge. cfg_we_i/cfg_wdata_i write the used journal length.
//
// Flow: a result passes through the command queue and then the output
// register after its header is taken. A commit with N queued writes gives N
// block writes, one per cycle while the receiver takes them; the executor is
// busy until the last one is shown. Other items leave the executor as it pops
// them, so between drains headers can be taken every cycle while results keep
// flowing. A two-entry command queue between classifier and executor lets
// headers keep arriving during a drain until the queue fills.
//
// Reset: the length is 8 (empty log), position 8, queue empty, no result
// pending. When the receiver stalls, the output register holds its result,
// the command queue fills and rec_i.ready drops.
// Depends on jrr_pkg, jrr_if, jrr_cmdq, jrr_front and jrr_back.
`default_nettype none

module journal_record_replay #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned BLOCK_BYTES = 4096,
  parameter int unsigned LOG_BLOCKS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i,
  jrr_in_if.sink           rec_i,
  jrr_out_if.source        res_o
);
  import jrr_pkg::*;

  jrr_cmd_t push_cmd;
  jrr_cmd_t pop_cmd;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  jrr_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .BLOCK_BYTES (BLOCK_BYTES),
    .LOG_BLOCKS  (LOG_BLOCKS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rec_i       (rec_i),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .full_i      (full)
  );

  jrr_cmdq u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_cmd_o  (pop_cmd)
  );

  jrr_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (pop_cmd),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/jrr_checker.sv
// Port-level checks on replay results, bound to the top level.
// Depends on jrr_pkg for the result kind codes.
`default_nettype none

module jrr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  out_kind_i,
  input wire logic [12:0] out_count_i,
  input wire logic        out_last_i
);
  import jrr_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
      && $stable(out_count_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // Single-result kinds always close their item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KIND_WRITE) |-> out_last_i)
    else $error("non-write result without last");

  // Restart clears the commit count
  a_restart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_RESTART) |-> (out_count_i == 13'd0))
    else $error("restart with nonzero commit count");

  // Commit results already include the commit
  a_commit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_kind_i == KIND_WRITE) || (out_kind_i == KIND_EMPTY))
      |-> (out_count_i != 13'd0))
    else $error("commit result with zero count");

  // Drain writes back to back with one count
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (out_kind_i == KIND_WRITE) && !out_last_i
      |=> out_valid_i && (out_kind_i == KIND_WRITE) && $stable(out_count_i))
    else $error("block write sequence broken");

endmodule

bind journal_record_replay jrr_checker u_jrr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_kind_i  (res_o.kind),
  .out_count_i (res_o.commits_applied),
  .out_last_i  (res_o.last)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for journal_record_replay: random record headers against an in-bench replay predictor.
// Depends on jrr_pkg, jrr_if and the journal_record_replay top level.
`timescale 1ns / 1ps

module tb;
  import jrr_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 285;
  localparam int QDEPTH         = 16;
  localparam int BLK_BYTES      = 4096;
  localparam int LOG_SPAN       = 16 * BLK_BYTES;
  localparam logic [31:0] DATA_SIZE = 32'(HDR_BYTES) + 32'd4 + 32'(BLK_BYTES);

  typedef struct packed {
    logic        action;
    logic [31:0] rec_type;
    logic [31:0] rec_size;
    logic [31:0] blk;
  } header_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] blk;
    logic [15:0] ofs;
    logic [12:0] commits;
    logic        last;
  } outcome_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_RANDOM, STALL_SPARSE, STALL_PERIODIC
  } stall_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [16:0] cfg_wdata_i = '0;

  jrr_in_if  rec_if ();
  jrr_out_if res_if ();

  journal_record_replay i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rec_i       (rec_if),
    .res_o       (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Headers waiting to be driven and results still owed by the block
  header_t  header_queue[$];
  outcome_t pending_results[$];
  int       hdrs_queued  = 0;
  int       mismatches   = 0;
  int       result_index = 0;

  // Replay state mirrored from the block
  logic [16:0] used_len  = 17'(HDR_BYTES);
  logic [16:0] log_pos   = 17'(HDR_BYTES);
  int          q_count   = 0;
  bit          halted    = 1'b0;
  logic [12:0] commits   = '0;
  logic [31:0] q_blk [QDEPTH];
  logic [15:0] q_ofs [QDEPTH];

  // Driver and receiver pacing
  logic    hdr_xfer    = 1'b0;
  header_t next_hdr;
  int      burst_left  = 1;
  int      gap_left    = 0;
  stall_e  stall_mode  = STALL_NONE;
  bit [6:0] stall_span = '0;

  function automatic void queue_outcome(kind_e k, logic [31:0] blk, logic [15:0] ofs,
                                        logic last);
    outcome_t o;
    o.kind    = k;
    o.blk     = blk;
    o.ofs     = ofs;
    o.commits = commits;
    o.last    = last;
    pending_results.push_back(o);
  endfunction

  function automatic void stop_replay();
    halted = 1'b1;
    queue_outcome(KIND_STOP, '0, '0, 1'b1);
  endfunction

  // Advance the mirrored replay by one accepted header and queue its results
  function automatic void replay_record(input header_t h);
    longint unsigned log_end;
    longint unsigned here;
    if (!h.action) begin
      log_pos = 17'(HDR_BYTES);
      q_count = 0;
      halted  = 1'b0;
      commits = '0;
      queue_outcome(KIND_RESTART, '0, '0, 1'b1);
      return;
    end
    if (halted) begin
      stop_replay();
      return;
    end
    log_end = (used_len < HDR_BYTES || used_len > LOG_SPAN) ? HDR_BYTES : used_len;
    here = log_pos;
    if (here + HDR_BYTES > log_end || h.rec_size < HDR_BYTES ||
        here + longint'(h.rec_size) > log_end) begin
      stop_replay();
    end else if (h.rec_type == TYPE_DATA) begin
      if (h.rec_size != DATA_SIZE || q_count >= QDEPTH) begin
        stop_replay();
      end else begin
        q_blk[q_count] = h.blk;
        q_ofs[q_count] = 16'(here + HDR_BYTES + 4);
        q_count++;
        log_pos = 17'(here + DATA_SIZE);
        queue_outcome(KIND_DATA, '0, '0, 1'b1);
      end
    end else if (h.rec_type == TYPE_COMMIT) begin
      if (h.rec_size != 32'(HDR_BYTES)) begin
        stop_replay();
      end else begin
        if (commits < COUNT_MAX) commits++;
        if (q_count == 0) queue_outcome(KIND_EMPTY, '0, '0, 1'b1);
        for (int i = 0; i < q_count; i++) begin
          queue_outcome(KIND_WRITE, q_blk[i], q_ofs[i], i == q_count - 1);
        end
        q_count = 0;
        log_pos = 17'(here + HDR_BYTES);
      end
    end else begin
      stop_replay();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                result_index, name, got, want));
    end
  endtask

  task automatic check_result();
    outcome_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %0d kind %0d arrived with nothing expected",
                                result_index, res_if.kind));
    end else begin
      want = pending_results.pop_front();
      check_field("kind", 32'(res_if.kind), 32'(want.kind));
      check_field("dest_block", res_if.dest_block, want.blk);
      check_field("image_offset", 32'(res_if.image_offset), 32'(want.ofs));
      check_field("commits_applied", 32'(res_if.commits_applied), 32'(want.commits));
      check_field("last", 32'(res_if.last), 32'(want.last));
    end
    result_index++;
  endtask

  // Predict on each header transfer, then check any result transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rec_if.valid && rec_if.ready) begin
        replay_record({rec_if.action, rec_if.record_type, rec_if.record_size,
                       rec_if.target_block});
      end
      if (res_if.valid && res_if.ready) check_result();
    end
    hdr_xfer <= rst_ni && rec_if.valid && rec_if.ready;
  end

  // Drive headers in bursts with random gaps; hold an item until it transfers
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rec_if.valid        <= 1'b0;
      rec_if.action       <= 1'b0;
      rec_if.record_type  <= '0;
      rec_if.record_size  <= '0;
      rec_if.target_block <= '0;
    end else if (!rec_if.valid || hdr_xfer) begin
      if (gap_left != 0 || header_queue.size() == 0) begin
        rec_if.valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        next_hdr = header_queue.pop_front();
        rec_if.valid        <= 1'b1;
        rec_if.action       <= next_hdr.action;
        rec_if.record_type  <= next_hdr.rec_type;
        rec_if.record_size  <= next_hdr.rec_size;
        rec_if.target_block <= next_hdr.blk;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Stall the result channel on a pattern that is picked anew when its span runs out
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = stall_e'($urandom_range(0, 3));
      stall_span = 7'($urandom_range(8, 64));
    end else begin
      stall_span--;
    end
    case (stall_mode)
      STALL_NONE:   res_if.ready <= 1'b1;
      STALL_RANDOM: res_if.ready <= 1'($urandom_range(0, 1));
      STALL_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
      default:      res_if.ready <= stall_span[1];
    endcase
  end

  task automatic push_hdr(input logic act, input logic [31:0] rec_type,
                          input logic [31:0] rec_size, input logic [31:0] blk);
    header_queue.push_back({act, rec_type, rec_size, blk});
    hdrs_queued++;
  endtask

  // Wait until every header has transferred and every result has come back
  task automatic settle();
    while (header_queue.size() != 0 || rec_if.valid || pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_used_len(input logic [16:0] len);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    used_len = len;
  endtask

  // First phases sweep the extremes of the length, later ones mostly a full log
  function automatic logic [16:0] pick_used_len(input int phase);
    case (phase)
      0: return 17'd0;
      1: return 17'd7;
      2: return 17'(LOG_SPAN + 1);
      3: return 17'h1FFFF;
      4: return 17'(HDR_BYTES);
      5: return 17'(LOG_SPAN);
      default: begin
        case ($urandom_range(0, 9))
          0, 1: return 17'($urandom_range(HDR_BYTES, LOG_SPAN));
          2: return 17'(HDR_BYTES + $urandom_range(0, 15) * DATA_SIZE +
                        $urandom_range(0, 6) * HDR_BYTES + $urandom_range(0, 7));
          3: return ($urandom_range(0, 1) == 1) ? 17'($urandom_range(0, 7))
                                                 : 17'($urandom_range(LOG_SPAN + 1, 17'h1FFFF));
          default: return 17'(LOG_SPAN);
        endcase
      end
    endcase
  endfunction

  // Restart, then mostly well-formed transactions with some broken records mixed in
  task automatic queue_session();
    int recs;
    push_hdr(1'b0, $urandom(), $urandom(), $urandom());
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 99) < 12) begin
        case ($urandom_range(0, 4))
          0: push_hdr(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom());
          1: push_hdr(1'b1, TYPE_DATA, DATA_SIZE + $urandom_range(0, 2) - 1, $urandom());
          2: push_hdr(1'b1, TYPE_COMMIT, $urandom_range(0, 16), $urandom());
          3: push_hdr(1'b1, $urandom() % 8, HDR_BYTES, $urandom());
          default: push_hdr(1'b1, TYPE_DATA, $urandom(), $urandom());
        endcase
      end else begin
        recs = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
        repeat (recs) push_hdr(1'b1, TYPE_DATA, DATA_SIZE, $urandom());
        push_hdr(1'b1, TYPE_COMMIT, HDR_BYTES, $urandom());
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset length is an empty log: a commit hits the end at once
    push_hdr(1'b0, $urandom(), $urandom(), $urandom());
    push_hdr(1'b1, TYPE_COMMIT, HDR_BYTES, '0);
    settle();

    // Full log: empty commit, extreme blocks, then each kind of bad record
    write_used_len(17'(LOG_SPAN));
    push_hdr(1'b0, '1, '1, '1);
    push_hdr(1'b1, TYPE_COMMIT, HDR_BYTES, '1);
    push_hdr(1'b1, TYPE_DATA, DATA_SIZE, '0);
    push_hdr(1'b1, TYPE_DATA, DATA_SIZE, '1);
    push_hdr(1'b1, TYPE_COMMIT, HDR_BYTES, '0);
    push_hdr(1'b1, TYPE_DATA, DATA_SIZE - 1, 32'h1234_5678);
    push_hdr(1'b1, TYPE_DATA, DATA_SIZE, 32'h0000_0042);
    push_hdr(1'b0, '0, '0, '0);
    push_hdr(1'b1, TYPE_DATA, '0, '0);
    push_hdr(1'b0, '0, '0, '0);
    push_hdr(1'b1, TYPE_COMMIT, '1, '0);
    push_hdr(1'b0, '0, '0, '0);
    push_hdr(1'b1, TYPE_COMMIT, 32'(HDR_BYTES) + 32'd1, '0);
    push_hdr(1'b0, '0, '0, '0);
    push_hdr(1'b1, '0, HDR_BYTES, '0);
    push_hdr(1'b0, '0, '0, '0);
    push_hdr(1'b1, '1, HDR_BYTES, '0);
    settle();

    // Room for one transaction and five spare bytes: fewer than a header remains
    write_used_len(17'(HDR_BYTES + DATA_SIZE + HDR_BYTES + 5));
    push_hdr(1'b0, '0, '0, '0);
    push_hdr(1'b1, TYPE_DATA, DATA_SIZE, 32'hDEAD_BEEF);
    push_hdr(1'b1, TYPE_COMMIT, HDR_BYTES, '0);
    push_hdr(1'b1, TYPE_COMMIT, HDR_BYTES, '0);
    settle();

    // Random phases, each with its own length setting
    for (phase = 0; hdrs_queued < ITEM_TARGET; phase++) begin
      write_used_len(pick_used_len(phase));
      repeat ($urandom_range(1, 3)) queue_session();
      settle();
    end

    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // End the run when nothing transfers for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((rec_if.valid && rec_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: journal_record_replay.f
hw/rtl/jrr_pkg.sv
hw/rtl/jrr_if.sv
hw/rtl/jrr_cmdq.sv
hw/rtl/jrr_front.sv
hw/rtl/jrr_back.sv
hw/rtl/journal_record_replay.sv
hw/rtl/jrr_checker.sv
tb/sv/tb.sv
